// ----- sv/ate_pkg.sv -----
`timescale 1ns / 1ps
package ate_pkg;

    // screen and parser geometry
    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int MAX_ARGS = 10;
    localparam int TAB_STEP = 4;

    localparam int COL_W = 7;
    localparam int ROW_W = 5;
    localparam int ARG_W = 16;
    localparam int ALU_W = 20;
    localparam int IDX_W = $clog2(MAX_ARGS);
    localparam int CNT_W = $clog2(MAX_ARGS + 1);

    localparam logic [ARG_W-1:0] ARG_MAX = 16'hFFFF;
    localparam logic [7:0] ATTR_RST = 8'h07;

    localparam logic [ALU_W-1:0] LIM_ROW  = ALU_W'(ROWS - 1);
    localparam logic [ALU_W-1:0] LIM_COL  = ALU_W'(COLS - 1);
    localparam logic [ALU_W-1:0] LIM_ARG  = ALU_W'(ARG_MAX);
    localparam logic [ALU_W-1:0] LIM_NONE = '1;

    // character codes
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_D0   = 8'h30;
    localparam logic [7:0] CH_D9   = 8'h39;
    localparam logic [7:0] CH_UP   = 8'h41;
    localparam logic [7:0] CH_DOWN = 8'h42;
    localparam logic [7:0] CH_FWD  = 8'h43;
    localparam logic [7:0] CH_BACK = 8'h44;
    localparam logic [7:0] CH_HOME = 8'h48;
    localparam logic [7:0] CH_ED   = 8'h4A;
    localparam logic [7:0] CH_SGR  = 8'h6D;

    // command kinds
    localparam logic [1:0] CMD_CELL   = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_POS    = 2'd3;

    // sgr codes
    localparam logic [ARG_W-1:0] SGR_RESET   = 16'd0;
    localparam logic [ARG_W-1:0] SGR_BOLD    = 16'd1;
    localparam logic [ARG_W-1:0] SGR_BLINK   = 16'd5;
    localparam logic [ARG_W-1:0] SGR_NOBOLD  = 16'd22;
    localparam logic [ARG_W-1:0] SGR_NOBLINK = 16'd25;
    localparam logic [ARG_W-1:0] SGR_FG_LO   = 16'd30;
    localparam logic [ARG_W-1:0] SGR_FG_HI   = 16'd37;
    localparam logic [ARG_W-1:0] SGR_BG_LO   = 16'd40;
    localparam logic [ARG_W-1:0] SGR_BG_HI   = 16'd47;
    localparam logic [ARG_W-1:0] ED_ALL      = 16'd2;

    // alu operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic             op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W-1:0] lim;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             over;
        logic             under;
    } t_alu_rsp;

    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       glyph;
        logic [7:0]       attr;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic [7:0] attr;
        logic       bold;
        logic       blink;
    } t_sgr;

    // ansi color index to attribute color
    function automatic logic [3:0] color_map(input logic [2:0] idx);
        logic [3:0] c;
        case (idx)
            3'd0:    c = 4'h0;
            3'd1:    c = 4'h4;
            3'd2:    c = 4'h2;
            3'd3:    c = 4'hE;
            3'd4:    c = 4'h1;
            3'd5:    c = 4'h5;
            3'd6:    c = 4'h3;
            3'd7:    c = 4'h7;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

    // one sgr parameter applied to the attribute state
    function automatic t_sgr sgr_step(input logic [ARG_W-1:0] p, input t_sgr s,
                                      input logic [7:0] dflt);
        t_sgr             o;
        logic [ARG_W-1:0] off;
        logic [3:0]       fg;
        logic [3:0]       bg;
        o   = s;
        off = '0;
        fg  = '0;
        bg  = '0;
        if (p == SGR_RESET) begin
            o.attr  = dflt;
            o.bold  = 1'b0;
            o.blink = 1'b0;
        end else if (p == SGR_BOLD) begin
            o.bold = 1'b1;
        end else if (p == SGR_BLINK) begin
            o.blink = 1'b1;
        end else if (p == SGR_NOBOLD) begin
            o.bold = 1'b0;
        end else if (p == SGR_NOBLINK) begin
            o.blink = 1'b0;
        end else if (p inside {[SGR_FG_LO:SGR_FG_HI]}) begin
            off    = p - SGR_FG_LO;
            fg     = color_map(off[2:0]) | {s.bold, 3'b000};
            o.attr = {s.blink, s.attr[6:4], fg};
        end else if (p inside {[SGR_BG_LO:SGR_BG_HI]}) begin
            off    = p - SGR_BG_LO;
            bg     = color_map(off[2:0]);
            o.attr = {s.blink, bg[2:0], s.attr[3:0]};
        end
        return o;
    endfunction

endpackage

// ----- sv/ate_alu.sv -----
`timescale 1ns / 1ps
module ate_alu import ate_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W:0] wide;
    logic           under;
    logic           over;

    always_comb begin
        if (i_req.op == ALU_SUB) begin
            wide = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            wide = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
    end

    // borrow out of a subtract means the result went below zero
    assign under = (i_req.op == ALU_SUB) && wide[ALU_W];
    assign over  = !under && (wide > {1'b0, i_req.lim});

    always_comb begin
        o_rsp.under = under;
        o_rsp.over  = over;
        if (under) begin
            o_rsp.res = '0;
        end else if (over) begin
            o_rsp.res = i_req.lim;
        end else begin
            o_rsp.res = wide[ALU_W-1:0];
        end
    end

endmodule

// ----- sv/ate_out.sv -----
`timescale 1ns / 1ps
module ate_out import ate_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_stall,
    output logic             o_slot_free,
    output logic             o_valid,
    output logic [1:0]       o_cmd_kind,
    output logic [ROW_W-1:0] o_cell_row,
    output logic [COL_W-1:0] o_cell_col,
    output logic [7:0]       o_glyph,
    output logic [7:0]       o_cell_attr,
    output logic             o_last_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_word;

    assign o_slot_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.valid) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid) begin
            r_word <= i_cmd;
        end
    end

    assign o_valid     = r_valid;
    assign o_cmd_kind  = r_word.kind;
    assign o_cell_row  = r_word.row;
    assign o_cell_col  = r_word.col;
    assign o_glyph     = r_word.glyph;
    assign o_cell_attr = r_word.attr;
    assign o_last_cmd  = r_word.last;

endmodule

// ----- sv/ate_seq.sv -----
`timescale 1ns / 1ps
module ate_seq import ate_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char_code,
    output logic       o_busy,
    input  logic [7:0] i_default_attr,
    input  logic       i_slot_free,
    output t_alu_req   o_alu_req,
    input  t_alu_rsp   i_alu_rsp,
    output t_cmd       o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIG1   = 4'd1;
    localparam logic [3:0] ST_DIG2   = 4'd2;
    localparam logic [3:0] ST_SGR    = 4'd3;
    localparam logic [3:0] ST_MOVE   = 4'd4;
    localparam logic [3:0] ST_HCOL   = 4'd5;
    localparam logic [3:0] ST_POS    = 4'd6;
    localparam logic [3:0] ST_CLR    = 4'd7;
    localparam logic [3:0] ST_CELL   = 4'd8;
    localparam logic [3:0] ST_COLADV = 4'd9;
    localparam logic [3:0] ST_ROWINC = 4'd10;
    localparam logic [3:0] ST_SCROLL = 4'd11;
    localparam logic [3:0] ST_BS     = 4'd12;
    localparam logic [3:0] ST_BSROW  = 4'd13;
    localparam logic [3:0] ST_ERASE  = 4'd14;

    logic [3:0]       r_state, n_state;
    logic [7:0]       r_char, n_char;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [7:0]       r_attr, n_attr;
    logic             r_bold, n_bold;
    logic             r_blink, n_blink;
    logic             r_seen, n_seen;
    logic             r_csi, n_csi;
    logic [ARG_W-1:0] r_args [MAX_ARGS];
    logic [ARG_W-1:0] n_args [MAX_ARGS];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [ALU_W-1:0] r_tmp, n_tmp;

    logic             accept;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] rd_idx;
    logic [ARG_W-1:0] arg_sel;
    logic [ARG_W-1:0] cnt0;
    logic [ARG_W-1:0] cnt1;
    t_sgr             sgr_in;
    t_sgr             sgr_out;

    assign o_busy  = (r_state != ST_IDLE);
    assign accept  = i_valid && (r_state == ST_IDLE);
    assign cnt_m1  = r_cnt - 1'b1;
    // one read port: walk index during sgr, current parameter otherwise
    assign rd_idx  = (r_state == ST_SGR) ? r_idx : cnt_m1[IDX_W-1:0];
    assign arg_sel = r_args[rd_idx];
    assign cnt0    = (r_args[0] == '0) ? ARG_W'(1) : r_args[0];
    assign cnt1    = (r_args[1] == '0) ? ARG_W'(1) : r_args[1];
    assign sgr_in  = '{attr: r_attr, bold: r_bold, blink: r_blink};
    assign sgr_out = sgr_step(arg_sel, sgr_in, i_default_attr);

    // operand selection for the shared adder
    always_comb begin
        o_alu_req = '{op: ALU_ADD, a: '0, b: '0, lim: LIM_NONE};
        case (r_state)
            ST_DIG1: begin
                o_alu_req.a = ALU_W'({arg_sel, 3'b000});
                o_alu_req.b = ALU_W'({arg_sel, 1'b0});
            end
            ST_DIG2: begin
                o_alu_req.a   = r_tmp;
                o_alu_req.b   = ALU_W'(r_char[3:0]);
                o_alu_req.lim = LIM_ARG;
            end
            ST_MOVE: begin
                case (r_char)
                    CH_UP: begin
                        o_alu_req = '{op: ALU_SUB, a: ALU_W'(r_row), b: ALU_W'(cnt0),
                                      lim: LIM_ROW};
                    end
                    CH_DOWN: begin
                        o_alu_req = '{op: ALU_ADD, a: ALU_W'(r_row), b: ALU_W'(cnt0),
                                      lim: LIM_ROW};
                    end
                    CH_FWD: begin
                        o_alu_req = '{op: ALU_ADD, a: ALU_W'(r_col), b: ALU_W'(cnt0),
                                      lim: LIM_COL};
                    end
                    CH_BACK: begin
                        o_alu_req = '{op: ALU_SUB, a: ALU_W'(r_col), b: ALU_W'(cnt0),
                                      lim: LIM_COL};
                    end
                    default: begin
                        o_alu_req = '{op: ALU_SUB, a: ALU_W'(cnt0), b: ALU_W'(1),
                                      lim: LIM_ROW};
                    end
                endcase
            end
            ST_HCOL: begin
                o_alu_req = '{op: ALU_SUB, a: ALU_W'(cnt1), b: ALU_W'(1), lim: LIM_COL};
            end
            ST_COLADV: begin
                o_alu_req.a   = ALU_W'(r_col);
                o_alu_req.b   = (r_char == CH_TAB) ? ALU_W'(TAB_STEP) : ALU_W'(1);
                o_alu_req.lim = LIM_COL;
            end
            ST_ROWINC: begin
                o_alu_req = '{op: ALU_ADD, a: ALU_W'(r_row), b: ALU_W'(1), lim: LIM_ROW};
            end
            ST_BS: begin
                o_alu_req = '{op: ALU_SUB, a: ALU_W'(r_col), b: ALU_W'(1), lim: LIM_COL};
            end
            ST_BSROW: begin
                o_alu_req = '{op: ALU_SUB, a: ALU_W'(r_row), b: ALU_W'(1), lim: LIM_ROW};
            end
            default: begin
            end
        endcase
    end

    // output word
    always_comb begin
        o_cmd = '{valid: 1'b0, kind: CMD_CELL, row: r_row, col: r_col,
                  glyph: CH_SP, attr: r_attr, last: 1'b0};
        case (r_state)
            ST_POS: begin
                o_cmd.valid = i_slot_free;
                o_cmd.kind  = CMD_POS;
                o_cmd.glyph = '0;
                o_cmd.attr  = '0;
                o_cmd.last  = 1'b1;
            end
            ST_CLR: begin
                o_cmd.valid = i_slot_free;
                o_cmd.kind  = CMD_CLEAR;
                o_cmd.row   = '0;
                o_cmd.col   = '0;
                o_cmd.last  = 1'b1;
            end
            ST_CELL: begin
                o_cmd.valid = i_slot_free;
                o_cmd.glyph = r_char;
            end
            ST_ERASE: begin
                o_cmd.valid = i_slot_free;
            end
            ST_SCROLL: begin
                o_cmd.valid = i_slot_free;
                o_cmd.kind  = CMD_SCROLL;
                o_cmd.row   = ROW_W'(ROWS - 1);
                o_cmd.col   = '0;
                o_cmd.attr  = i_default_attr;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_char  = r_char;
        n_row   = r_row;
        n_col   = r_col;
        n_attr  = r_attr;
        n_bold  = r_bold;
        n_blink = r_blink;
        n_seen  = r_seen;
        n_csi   = r_csi;
        n_args  = r_args;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_tmp   = r_tmp;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_char = i_char_code;
                    if (i_char_code == CH_ESC) begin
                        n_seen = 1'b1;
                        n_csi  = 1'b0;
                        n_cnt  = CNT_W'(1);
                        for (int i = 0; i < MAX_ARGS; i++) n_args[i] = '0;
                    end else if (r_seen && !r_csi && i_char_code == CH_LBR) begin
                        n_seen = 1'b1;
                        n_csi  = 1'b1;
                        n_cnt  = CNT_W'(1);
                        for (int i = 0; i < MAX_ARGS; i++) n_args[i] = '0;
                    end else if (r_seen && r_csi) begin
                        if (i_char_code inside {[CH_D0:CH_D9]}) begin
                            n_state = ST_DIG1;
                        end else if (i_char_code == CH_SEMI) begin
                            if (r_cnt < CNT_W'(MAX_ARGS)) begin
                                n_cnt = r_cnt + 1'b1;
                            end
                        end else begin
                            case (i_char_code)
                                CH_UP, CH_DOWN, CH_FWD, CH_BACK, CH_HOME: begin
                                    n_state = ST_MOVE;
                                end
                                CH_SGR: begin
                                    n_idx   = '0;
                                    n_state = ST_SGR;
                                end
                                default: begin
                                    // erase display and unknown finals end the sequence here
                                    if (i_char_code == CH_ED && r_args[0] == ED_ALL) begin
                                        n_row   = '0;
                                        n_col   = '0;
                                        n_state = ST_CLR;
                                    end
                                    n_seen = 1'b0;
                                    n_csi  = 1'b0;
                                    n_cnt  = CNT_W'(1);
                                    for (int i = 0; i < MAX_ARGS; i++) n_args[i] = '0;
                                end
                            endcase
                        end
                    end else begin
                        n_seen = 1'b0;
                        n_csi  = 1'b0;
                        case (i_char_code)
                            CH_BS: begin
                                n_state = ST_BS;
                            end
                            CH_LF, CH_CR: begin
                                n_col   = '0;
                                n_state = ST_ROWINC;
                            end
                            CH_TAB: begin
                                n_state = ST_COLADV;
                            end
                            default: begin
                                n_state = ST_CELL;
                            end
                        endcase
                    end
                end
            end
            ST_DIG1: begin
                n_tmp   = i_alu_rsp.res;
                n_state = ST_DIG2;
            end
            ST_DIG2: begin
                n_args[cnt_m1[IDX_W-1:0]] = i_alu_rsp.res[ARG_W-1:0];
                n_state = ST_IDLE;
            end
            ST_SGR: begin
                n_attr  = sgr_out.attr;
                n_bold  = sgr_out.bold;
                n_blink = sgr_out.blink;
                if (r_idx == cnt_m1[IDX_W-1:0]) begin
                    n_seen  = 1'b0;
                    n_csi   = 1'b0;
                    n_cnt   = CNT_W'(1);
                    for (int i = 0; i < MAX_ARGS; i++) n_args[i] = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_MOVE: begin
                if (r_char == CH_HOME) begin
                    n_row   = i_alu_rsp.res[ROW_W-1:0];
                    n_state = ST_HCOL;
                end else begin
                    if (r_char == CH_UP || r_char == CH_DOWN) begin
                        n_row = i_alu_rsp.res[ROW_W-1:0];
                    end else begin
                        n_col = i_alu_rsp.res[COL_W-1:0];
                    end
                    n_seen  = 1'b0;
                    n_csi   = 1'b0;
                    n_cnt   = CNT_W'(1);
                    for (int i = 0; i < MAX_ARGS; i++) n_args[i] = '0;
                    n_state = ST_POS;
                end
            end
            ST_HCOL: begin
                n_col   = i_alu_rsp.res[COL_W-1:0];
                n_seen  = 1'b0;
                n_csi   = 1'b0;
                n_cnt   = CNT_W'(1);
                for (int i = 0; i < MAX_ARGS; i++) n_args[i] = '0;
                n_state = ST_POS;
            end
            ST_CELL: begin
                if (i_slot_free) begin
                    n_state = ST_COLADV;
                end
            end
            ST_COLADV: begin
                if (i_alu_rsp.over) begin
                    n_col   = '0;
                    n_state = ST_ROWINC;
                end else begin
                    n_col   = i_alu_rsp.res[COL_W-1:0];
                    n_state = ST_POS;
                end
            end
            ST_ROWINC: begin
                // clamped result keeps the cursor on the last row on overflow
                n_row   = i_alu_rsp.res[ROW_W-1:0];
                n_state = i_alu_rsp.over ? ST_SCROLL : ST_POS;
            end
            ST_BS: begin
                if (i_alu_rsp.under) begin
                    n_state = ST_BSROW;
                end else begin
                    n_col   = i_alu_rsp.res[COL_W-1:0];
                    n_state = ST_ERASE;
                end
            end
            ST_BSROW: begin
                if (i_alu_rsp.under) begin
                    n_state = ST_POS;
                end else begin
                    n_row   = i_alu_rsp.res[ROW_W-1:0];
                    n_col   = COL_W'(COLS - 1);
                    n_state = ST_ERASE;
                end
            end
            ST_SCROLL, ST_ERASE: begin
                if (i_slot_free) begin
                    n_state = ST_POS;
                end
            end
            ST_POS, ST_CLR: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_attr  <= ATTR_RST;
            r_bold  <= 1'b0;
            r_blink <= 1'b0;
            r_seen  <= 1'b0;
            r_csi   <= 1'b0;
            r_cnt   <= CNT_W'(1);
            for (int i = 0; i < MAX_ARGS; i++) r_args[i] <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_attr  <= n_attr;
            r_bold  <= n_bold;
            r_blink <= n_blink;
            r_seen  <= n_seen;
            r_csi   <= n_csi;
            r_cnt   <= n_cnt;
            r_args  <= n_args;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_idx  <= n_idx;
        r_tmp  <= n_tmp;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt >= CNT_W'(1) && r_cnt <= CNT_W'(MAX_ARGS))
        else $error("parameter count out of range");

    a_csi_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_csi |-> r_seen)
        else $error("csi flag without escape");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_W'(ROWS - 1) && r_col <= COL_W'(COLS - 1))
        else $error("cursor off screen");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid && o_cmd.last |=> r_state == ST_IDLE)
        else $error("last word did not end the character");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid && o_cmd.kind == CMD_SCROLL |-> r_row == ROW_W'(ROWS - 1))
        else $error("scroll issued with cursor above last row");

endmodule

// ----- sv/ansi_text_terminal_engine.sv -----
// Character-stream terminal engine: one byte per input word, turned into screen commands
// (cell write, scroll, clear, cursor position) for an external display memory, with the
// final command of each byte flagged by o_last_cmd. A byte is taken only while o_stall is
// low; bytes that emit nothing (escape, bracket, semicolon) leave the sequencer idle,
// while digits, cursor, erase and SGR finals, printable and control bytes are worked
// through one shared add/clamp unit under a small sequencer, with o_stall held high until
// the byte is done. Each emitted command also waits for as long as i_stall keeps the output
// register full. default_attr is to be written through the cfg channel only while the
// engine is idle; the user must keep to this, the block itself does not enforce it.
`timescale 1ns / 1ps
module ansi_text_terminal_engine import ate_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_char_code,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_cmd_kind,
    output logic [ROW_W-1:0] o_cell_row,
    output logic [COL_W-1:0] o_cell_col,
    output logic [7:0]       o_glyph,
    output logic [7:0]       o_cell_attr,
    output logic             o_last_cmd,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data
);

    logic [7:0] r_default_attr;
    logic       slot_free;
    t_alu_req   alu_req;
    t_alu_rsp   alu_rsp;
    t_cmd       cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= ATTR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_default_attr <= i_cfg_data;
        end
    end

    ate_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_char_code    (i_char_code),
        .o_busy         (o_stall),
        .i_default_attr (r_default_attr),
        .i_slot_free    (slot_free),
        .o_alu_req      (alu_req),
        .i_alu_rsp      (alu_rsp),
        .o_cmd          (cmd)
    );

    ate_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    ate_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_stall     (i_stall),
        .o_slot_free (slot_free),
        .o_valid     (o_valid),
        .o_cmd_kind  (o_cmd_kind),
        .o_cell_row  (o_cell_row),
        .o_cell_col  (o_cell_col),
        .o_glyph     (o_glyph),
        .o_cell_attr (o_cell_attr),
        .o_last_cmd  (o_last_cmd)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import ate_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 40;
    localparam int HOLD_TICKS   = 300;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_mode;

    typedef struct {
        logic [1:0]       kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       glyph;
        logic [7:0]       attr;
        logic             is_last;
    } t_screen_cmd;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_char_code;
    logic             o_valid;
    logic             i_stall;
    logic [1:0]       o_cmd_kind;
    logic [ROW_W-1:0] o_cell_row;
    logic [COL_W-1:0] o_cell_col;
    logic [7:0]       o_glyph;
    logic [7:0]       o_cell_attr;
    logic             o_last_cmd;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_data;

    ansi_text_terminal_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cmd_kind  (o_cmd_kind),
        .o_cell_row  (o_cell_row),
        .o_cell_col  (o_cell_col),
        .o_glyph     (o_glyph),
        .o_cell_attr (o_cell_attr),
        .o_last_cmd  (o_last_cmd),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // terminal state as the engine should hold it
    int         cur_col;
    int         cur_row;
    logic [7:0] attr_now;
    logic [7:0] dflt_attr;
    logic       bold_on;
    logic       blink_on;
    logic       seen_esc;
    logic       in_csi;
    int         arg_cnt;
    int         csi_arg [MAX_ARGS];

    logic [3:0] ansi_color [8] = '{4'h0, 4'h4, 4'h2, 4'hE, 4'h1, 4'h5, 4'h3, 4'h7};

    t_screen_cmd expected_cmds [$];
    t_screen_cmd step_cmds [$];

    int          mismatches = 0;
    int          chars_sent = 0;
    int          cmds_seen = 0;
    int          scrolls_seen = 0;
    int          clears_seen = 0;
    int          cfg_writes = 0;
    int          cycle_count = 0;

    int          burst_left = 0;
    int          gap_max = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          hold_request = 0;
    int          hold_left = 0;
    logic [15:0] stall_pat = 16'h0F35;
    int          pat_count = 0;

    function automatic void clear_parser();
        seen_esc = 1'b0;
        in_csi   = 1'b0;
        arg_cnt  = 1;
        foreach (csi_arg[i]) csi_arg[i] = 0;
    endfunction

    function automatic void reset_terminal();
        cur_col   = 0;
        cur_row   = 0;
        attr_now  = ATTR_RST;
        dflt_attr = ATTR_RST;
        bold_on   = 1'b0;
        blink_on  = 1'b0;
        clear_parser();
    endfunction

    function automatic void queue_cmd(input logic [1:0] kind, input int row, input int col,
                                      input logic [7:0] glyph, input logic [7:0] attr);
        t_screen_cmd t;
        t.kind    = kind;
        t.row     = ROW_W'(row);
        t.col     = COL_W'(col);
        t.glyph   = glyph;
        t.attr    = attr;
        t.is_last = 1'b0;
        step_cmds.push_back(t);
    endfunction

    // zero counts as one for moves and home
    function automatic int at_least_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic void apply_sgr();
        int         p;
        logic [3:0] fg;
        for (int i = 0; i < arg_cnt && i < MAX_ARGS; i++) begin
            p = csi_arg[i];
            if (p == SGR_RESET) begin
                attr_now = dflt_attr;
                bold_on  = 1'b0;
                blink_on = 1'b0;
            end else if (p == SGR_BOLD) begin
                bold_on = 1'b1;
            end else if (p == SGR_BLINK) begin
                blink_on = 1'b1;
            end else if (p == SGR_NOBOLD) begin
                bold_on = 1'b0;
            end else if (p == SGR_NOBLINK) begin
                blink_on = 1'b0;
            end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
                fg       = ansi_color[p - SGR_FG_LO] | {bold_on, 3'b000};
                attr_now = {blink_on, attr_now[6:4], fg};
            end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
                fg       = ansi_color[p - SGR_BG_LO];
                attr_now = {blink_on, fg[2:0], attr_now[3:0]};
            end
        end
    endfunction

    function automatic void finish_csi(input logic [7:0] c);
        int a0;
        int a1;
        a0 = csi_arg[0];
        a1 = csi_arg[1];
        case (c)
            CH_UP: begin
                cur_row = (at_least_one(a0) > cur_row) ? 0 : cur_row - at_least_one(a0);
                queue_cmd(CMD_POS, cur_row, cur_col, 8'h00, 8'h00);
            end
            CH_DOWN: begin
                cur_row = (cur_row + at_least_one(a0) > ROWS - 1) ? ROWS - 1
                                                                  : cur_row + at_least_one(a0);
                queue_cmd(CMD_POS, cur_row, cur_col, 8'h00, 8'h00);
            end
            CH_FWD: begin
                cur_col = (cur_col + at_least_one(a0) > COLS - 1) ? COLS - 1
                                                                  : cur_col + at_least_one(a0);
                queue_cmd(CMD_POS, cur_row, cur_col, 8'h00, 8'h00);
            end
            CH_BACK: begin
                cur_col = (at_least_one(a0) > cur_col) ? 0 : cur_col - at_least_one(a0);
                queue_cmd(CMD_POS, cur_row, cur_col, 8'h00, 8'h00);
            end
            CH_HOME: begin
                cur_row = at_least_one(a0) - 1;
                if (cur_row > ROWS - 1) cur_row = ROWS - 1;
                cur_col = at_least_one(a1) - 1;
                if (cur_col > COLS - 1) cur_col = COLS - 1;
                queue_cmd(CMD_POS, cur_row, cur_col, 8'h00, 8'h00);
            end
            CH_ED: begin
                if (a0 == ED_ALL) begin
                    cur_row = 0;
                    cur_col = 0;
                    queue_cmd(CMD_CLEAR, 0, 0, CH_SP, attr_now);
                end
            end
            CH_SGR: apply_sgr();
            default: ;
        endcase
    endfunction

    function automatic void draw_char(input logic [7:0] c);
        if (c == CH_BS) begin
            if (cur_col > 0) begin
                cur_col--;
                queue_cmd(CMD_CELL, cur_row, cur_col, CH_SP, attr_now);
            end else if (cur_row > 0) begin
                cur_row--;
                cur_col = COLS - 1;
                queue_cmd(CMD_CELL, cur_row, cur_col, CH_SP, attr_now);
            end
        end else if (c == CH_LF || c == CH_CR) begin
            cur_col = 0;
            cur_row++;
        end else if (c == CH_TAB) begin
            cur_col += TAB_STEP;
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
        end else begin
            queue_cmd(CMD_CELL, cur_row, cur_col, c, attr_now);
            cur_col++;
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
        end
        if (cur_row >= ROWS) begin
            cur_row = ROWS - 1;
            queue_cmd(CMD_SCROLL, ROWS - 1, 0, CH_SP, dflt_attr);
        end
        queue_cmd(CMD_POS, cur_row, cur_col, 8'h00, 8'h00);
    endfunction

    // screen commands caused by one character word
    function automatic void predict_char(input logic [7:0] c);
        int          v;
        t_screen_cmd t;
        if (c == CH_ESC) begin
            clear_parser();
            seen_esc = 1'b1;
        end else if (seen_esc && !in_csi && c == CH_LBR) begin
            clear_parser();
            seen_esc = 1'b1;
            in_csi   = 1'b1;
        end else if (seen_esc && in_csi && c >= CH_D0 && c <= CH_D9) begin
            v = csi_arg[arg_cnt - 1] * 10 + int'(c) - int'(CH_D0);
            csi_arg[arg_cnt - 1] = (v > int'(ARG_MAX)) ? int'(ARG_MAX) : v;
        end else if (seen_esc && in_csi && c == CH_SEMI) begin
            if (arg_cnt < MAX_ARGS) arg_cnt++;
        end else if (seen_esc && in_csi) begin
            finish_csi(c);
            clear_parser();
        end else begin
            seen_esc = 1'b0;
            in_csi   = 1'b0;
            draw_char(c);
        end
        for (int i = 0; i < step_cmds.size(); i++) begin
            t = step_cmds[i];
            t.is_last = (i == step_cmds.size() - 1);
            expected_cmds.push_back(t);
        end
        step_cmds.delete();
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_screen_cmd want;
        if (i_rst_n && o_valid && !i_stall) begin
            cmds_seen++;
            if (o_cmd_kind == CMD_SCROLL) scrolls_seen++;
            if (o_cmd_kind == CMD_CLEAR) clears_seen++;
            if (expected_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected command: kind %0d row %0d col %0d glyph %h %s",
                             o_cmd_kind, o_cell_row, o_cell_col, o_glyph,
                             $sformatf("attr %h last %0d", o_cell_attr, o_last_cmd));
            end else begin
                want = expected_cmds.pop_front();
                if (o_cmd_kind !== want.kind || o_cell_row !== want.row ||
                    o_cell_col !== want.col || o_glyph !== want.glyph ||
                    o_cell_attr !== want.attr || o_last_cmd !== want.is_last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("command %0d: expected kind %0d row %0d col %0d %s",
                                 cmds_seen, want.kind, want.row, want.col,
                                 $sformatf("glyph %h attr %h last %0d",
                                           want.glyph, want.attr, want.is_last));
                        $display("    got kind %0d row %0d col %0d %s",
                                 o_cmd_kind, o_cell_row, o_cell_col,
                                 $sformatf("glyph %h attr %h last %0d",
                                           o_glyph, o_cell_attr, o_last_cmd));
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        pat_count++;
        if (pat_count % 64 == 0) stall_pat = 16'($urandom);
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:   i_stall <= 1'b0;
                STALL_RANDOM: i_stall <= ($urandom_range(0, 99) < 30);
                default: begin
                    i_stall <= stall_pat[0];
                    stall_pat = {stall_pat[0], stall_pat[15:1]};
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding",
                     cycle_count, expected_cmds.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (o_stall);
        predict_char(c);
        chars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gap_max > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat ($urandom_range(0, gap_max - 1)) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_csi(input string body);
        send_char(CH_ESC);
        send_char(CH_LBR);
        send_string(body);
    endtask

    task automatic send_number(input int v);
        int digit [10];
        int n;
        n = 0;
        do begin
            digit[n] = v % 10;
            v = v / 10;
            n++;
        end while (v > 0 && n < 10);
        for (int i = n - 1; i >= 0; i--) send_char(8'(int'(CH_D0) + digit[i]));
    endtask

    // sender pauses until every command has arrived and the engine has gone quiet
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_default_attr(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        dflt_attr = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_sgr_code();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 1 : 5)
                                                 : ($urandom_range(0, 1) ? 22 : 25);
            2, 3, 4: return $urandom_range(SGR_FG_LO, SGR_FG_HI);
            5, 6, 7: return $urandom_range(SGR_BG_LO, SGR_BG_HI);
            8:       return $urandom_range(0, 60);
            default: return $urandom_range(0, 1) ? -1 : $urandom_range(0, 9999999);
        endcase
    endfunction

    // control sequence with random parameters, mostly with a known final byte
    task automatic send_csi_random();
        int         sel;
        int         nparams;
        int         v;
        logic [7:0] fin;
        sel = $urandom_range(0, 9);
        send_char(CH_ESC);
        send_char(CH_LBR);
        nparams = (sel >= 6 && sel <= 8) ? $urandom_range(1, 12) :
                  (sel == 4) ? $urandom_range(0, 3) : $urandom_range(0, 2);
        for (int i = 0; i < nparams; i++) begin
            if (i > 0) send_char(CH_SEMI);
            if (sel >= 6 && sel <= 8) v = pick_sgr_code();
            else if (sel == 5) v = $urandom_range(0, 3) ? 2 : $urandom_range(0, 4);
            else if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 999999);
            else if ($urandom_range(0, 7) == 0) v = -1;
            else v = $urandom_range(0, 90);
            if (v >= 0) send_number(v);
        end
        case (sel)
            0:       fin = CH_UP;
            1:       fin = CH_DOWN;
            2:       fin = CH_FWD;
            3:       fin = CH_BACK;
            4:       fin = CH_HOME;
            5:       fin = CH_ED;
            6, 7, 8: fin = CH_SGR;
            default: fin = 8'($urandom_range(0, 255));
        endcase
        send_char(fin);
    endtask

    task automatic send_text_random(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) send_char(8'($urandom_range(8'h20, 8'h7E)));
            else if (r < 78) send_char(CH_LF);
            else if (r < 82) send_char(CH_CR);
            else if (r < 88) send_char(CH_TAB);
            else if (r < 94) send_char(CH_BS);
            else send_char(8'($urandom_range(0, 255)));
        end
    endtask

    // broken and stray escape sequences
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: begin
                send_char(CH_ESC);
                send_char(8'($urandom_range(0, 255)));
            end
            1: send_char(8'($urandom_range(0, 255)));
            2: begin
                send_csi("");
                send_number($urandom_range(0, 500));
                send_char(CH_ESC);
            end
            default: begin
                send_csi("");
                send_char(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic run_random_phase(input int n_chars);
        int target;
        int r;
        target = chars_sent + n_chars;
        while (chars_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 50) send_csi_random();
            else if (r < 85) send_text_random($urandom_range(1, 16));
            else send_noise();
        end
    endtask

    task automatic test_plain_text();
        stall_mode = STALL_RANDOM;
        gap_max    = 4;
        send_char(8'h00);
        send_char(8'hFF);
        send_string("Az");
        send_char(8'h7F);
        send_char(CH_TAB);
        send_char(CH_BS);
        send_char(CH_CR);
        // column 0 below the top row wraps back to the row above
        send_char(CH_BS);
        send_char(CH_LF);
        send_csi("H");
        send_char(CH_BS);
        send_csi("1;79H");
        send_char(CH_TAB);
    endtask

    task automatic test_cursor_moves();
        send_csi("5B");
        send_csi("3C");
        send_csi("A");
        send_csi("9D");
        send_csi("40A");
        send_csi("6553599999C");
        send_csi("99;200H");
        // last cell of the last row: wrap forces a scroll
        send_char("Z");
        send_csi("2J");
        send_csi("0J");
        send_csi("q");
        send_char(CH_ESC);
        send_char("x");
        send_char(CH_ESC);
        send_csi("3B");
        send_csi("12");
        send_csi("C");
        send_csi("1;2;3;4;5;6;7;8;9;10;11;12;13H");
    endtask

    task automatic test_sgr_attrs();
        send_csi("1;31;44;5m");
        send_char("X");
        send_csi("32;47m");
        send_char("X");
        send_csi("0m");
        send_char("Y");
        send_csi("22;25;37;40m");
        send_char("Z");
        send_csi("5;1;1;1;1;1;1;1;1;1;33m");
        send_char("W");
        wait_idle();
    endtask

    // receiver holds off long enough for the engine to stall its input
    task automatic test_output_holdoff();
        stall_mode = STALL_NONE;
        gap_max    = 0;
        @(posedge i_clk);
        hold_request = HOLD_TICKS;
        for (int i = 0; i < 60; i++) send_char(8'($urandom_range(8'h20, 8'h7E)));
        wait_idle();
    endtask

    task automatic test_default_attr_phases();
        logic [7:0] setting [4];
        setting = '{8'h00, 8'hFF, 8'($urandom), ATTR_RST};
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_default_attr(setting[ph]);
            case (ph)
                0: begin stall_mode = STALL_NONE;    gap_max = 0;  end
                1: begin stall_mode = STALL_RANDOM;  gap_max = 6;  end
                2: begin stall_mode = STALL_PATTERN; gap_max = 3;  end
                default: begin stall_mode = STALL_RANDOM; gap_max = 12; end
            endcase
            send_csi("0m");
            send_csi("99;99H");
            send_string("ab");
            run_random_phase(35);
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_char_code = 8'h00;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 8'h00;
        reset_terminal();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_text();
        test_cursor_moves();
        test_sgr_attrs();
        test_output_holdoff();
        test_default_attr_phases();

        $display("sent %0d characters, checked %0d commands (%0d scrolls, %0d clears)",
                 chars_sent, cmds_seen, scrolls_seen, clears_seen);
        $display("default_attr written %0d times, mismatches %0d", cfg_writes, mismatches);
        if (mismatches == 0 && expected_cmds.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ate_pkg.sv
sv/ate_alu.sv
sv/ate_out.sv
sv/ate_seq.sv
sv/ansi_text_terminal_engine.sv
dv/tb.sv
